// ===== design/hwc_pkg.sv =====
package hwc_pkg;

    localparam int LEN_W   = 13;
    localparam int IDX_W   = 12;
    localparam int TURN_W  = 32;
    localparam int ANG_W   = 31;
    localparam int SQ_W    = 32;
    localparam int HORNER_STEPS = 7;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_SHORT = 2'd2;

    localparam logic REG_LENGTH = 1'b0;
    localparam logic REG_MODE   = 1'b1;

    localparam logic [31:0] PI_Q30  = 32'd3373259426;
    localparam logic [30:0] Q30_ONE = 31'h4000_0000;

    // Divisors of the cosine series and their truncated reciprocals, floor(2^32 / k).
    localparam logic [7:0] HORNER_K [HORNER_STEPS] = '{
        8'd182, 8'd132, 8'd90, 8'd56, 8'd30, 8'd12, 8'd2
    };
    localparam logic [31:0] HORNER_M [HORNER_STEPS] = '{
        32'd23598721, 32'd32537631, 32'd47721858, 32'd76695844,
        32'd143165576, 32'd357913941, 32'd2147483648
    };

    typedef struct packed {
        logic       valid;
        logic [1:0] status;
        logic       flip;
    } hwc_tag_t;

endpackage

// ===== design/hamming_window_coefficient.sv =====
// Throughput: one request per clock; the pipeline freezes only while a finished result is
// stalled. Between an accepted request and its coefficient at the output register lie a
// chain of 32 one-bit division cells for the phase and seven three-stage cosine cells,
// each holding two multipliers.
// Reset (rst_n, asynchronous): all stages empty, length 4096, periodic mode.
module hamming_window_coefficient #(
    parameter int MAX_LENGTH     = 4096,
    parameter int COEF_FRAC_BITS = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [2:0]                paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready,
    input  logic                      sample_valid,
    output logic                      sample_stall,
    input  logic [11:0]               sample_index,
    output logic                      coef_valid,
    input  logic                      coef_stall,
    output logic [COEF_FRAC_BITS:0]   coefficient,
    output logic [1:0]                status
);
    import hwc_pkg::*;

    localparam int SH    = 30 - COEF_FRAC_BITS;
    localparam int NUM_W = 36;
    localparam int BW    = NUM_W - SH;
    localparam logic [63:0] M46 = (64'd1 << BW) / 64'd46;
    localparam int MW    = BW - 5;

    logic [LEN_W-1:0] length_reg;
    logic             periodic_reg;

    logic             adv;
    logic             accept;
    logic [LEN_W-1:0] len_sat;
    logic [LEN_W-1:0] den;
    logic [1:0]       status_next;
    logic [LEN_W-1:0] rem0;

    hwc_tag_t         s0_tag_reg;
    logic [LEN_W-1:0] s0_den_reg;
    logic [LEN_W-1:0] s0_rem_reg;
    logic [TURN_W-1:0] s0_dq_reg;

    hwc_tag_t         dv_tag [0:TURN_W];
    logic [LEN_W-1:0] dv_den [0:TURN_W];
    logic [LEN_W-1:0] dv_rem [0:TURN_W];
    logic [TURN_W-1:0] dv_dq [0:TURN_W];

    logic [TURN_W-1:0] t_half;
    logic [TURN_W-1:0] t_quad;
    logic              flip_next;
    hwc_tag_t          rd_tag_reg;
    logic [ANG_W-1:0]  rd_t_reg;

    logic [63:0]       ang_prod;
    hwc_tag_t          x_tag_reg;
    logic [ANG_W-1:0]  x_reg;

    logic [61:0]       sq_prod;
    hwc_tag_t          x2_tag_reg;
    logic [SQ_W-1:0]   x2_reg;

    hwc_tag_t          hn_tag [0:HORNER_STEPS];
    logic [SQ_W-1:0]   hn_x2 [0:HORNER_STEPS];
    logic [ANG_W-1:0]  hn_h [0:HORNER_STEPS];

    logic [NUM_W-1:0]  c21;
    logic [NUM_W-1:0]  num;
    logic [NUM_W-1:0]  num_rnd;
    hwc_tag_t          f1_tag_reg;
    logic [BW-1:0]     b_reg;

    logic [2*BW-1:0]   recip_prod;
    hwc_tag_t          f2_tag_reg;
    logic [BW-1:0]     b2_reg;
    logic [BW-1:0]     q0_reg;

    logic [BW-1:0]     fin_rem;
    logic [BW-1:0]     fin_q;
    logic              coef_valid_reg;
    logic [1:0]        status_reg;
    logic [COEF_FRAC_BITS:0] coef_reg;

    // Configuration port.
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_MODE) ? {31'b0, periodic_reg} : {19'b0, length_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_reg   <= LEN_W'(4096);
            periodic_reg <= 1'b1;
        end
        else if (psel && penable && pwrite)
        begin
            case (paddr[2])
                REG_LENGTH: length_reg   <= pwdata[LEN_W-1:0];
                REG_MODE:   periodic_reg <= pwdata[0];
                default:    length_reg   <= length_reg;
            endcase
        end
    end

    // The whole pipeline moves together unless a finished result is held back.
    assign adv          = !coef_valid_reg || !coef_stall;
    assign sample_stall = !adv;
    assign accept       = sample_valid && adv;

    always_comb
    begin
        len_sat = ({19'b0, length_reg} > 32'(MAX_LENGTH)) ? LEN_W'(MAX_LENGTH) : length_reg;
        den     = periodic_reg ? len_sat : LEN_W'(len_sat - LEN_W'(1));
        if (!periodic_reg && len_sat < LEN_W'(2))
        begin
            status_next = ST_SHORT;
        end
        else if ({1'b0, sample_index} >= len_sat)
        begin
            status_next = ST_RANGE;
        end
        else
        begin
            status_next = ST_OK;
        end
        // The last index of a symmetric window lands on a whole turn, which wraps to zero.
        rem0 = ({1'b0, sample_index} == den) ? '0 : {1'b0, sample_index};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_tag_reg <= '0;
        end
        else if (adv)
        begin
            s0_tag_reg <= '{valid: accept, status: status_next, flip: 1'b0};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s0_den_reg        <= den;
            s0_rem_reg        <= rem0;
            s0_dq_reg         <= TURN_W'(den >> 1);
        end
    end

    assign dv_tag[0] = s0_tag_reg;
    assign dv_den[0] = s0_den_reg;
    assign dv_rem[0] = s0_rem_reg;
    assign dv_dq[0]  = s0_dq_reg;

    for (genvar i = 0; i < TURN_W; i++)
    begin : g_div
        hwc_div_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .adv   (adv),
            .tag_i (dv_tag[i]),
            .den_i (dv_den[i]),
            .rem_i (dv_rem[i]),
            .dq_i  (dv_dq[i]),
            .tag_o (dv_tag[i+1]),
            .den_o (dv_den[i+1]),
            .rem_o (dv_rem[i+1]),
            .dq_o  (dv_dq[i+1])
        );
    end

    // Fold the phase into the first quadrant, noting when the cosine changes sign.
    always_comb
    begin
        t_half = (dv_dq[TURN_W] > 32'h8000_0000) ? TURN_W'(33'h1_0000_0000 - {1'b0, dv_dq[TURN_W]})
                                                 : dv_dq[TURN_W];
        flip_next = (t_half > 32'h4000_0000);
        t_quad    = flip_next ? (32'h8000_0000 - t_half) : t_half;
        ang_prod  = {33'b0, rd_t_reg} * {32'b0, PI_Q30} + 64'h4000_0000;
        sq_prod   = {31'b0, x_reg} * {31'b0, x_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_tag_reg <= '0;
            x_tag_reg  <= '0;
            x2_tag_reg <= '0;
        end
        else if (adv)
        begin
            rd_tag_reg <= '{valid: dv_tag[TURN_W].valid, status: dv_tag[TURN_W].status,
                            flip: flip_next};
            x_tag_reg  <= rd_tag_reg;
            x2_tag_reg <= x_tag_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rd_t_reg          <= t_quad[ANG_W-1:0];
            x_reg             <= ang_prod[61:31];
            x2_reg            <= sq_prod[61:30];
        end
    end

    assign hn_tag[0] = x2_tag_reg;
    assign hn_x2[0]  = x2_reg;
    assign hn_h[0]   = Q30_ONE;

    for (genvar j = 0; j < HORNER_STEPS; j++)
    begin : g_cos
        hwc_horner_cell #(
            .STEP (j)
        ) u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .adv   (adv),
            .tag_i (hn_tag[j]),
            .x2_i  (hn_x2[j]),
            .h_i   (hn_h[j]),
            .tag_o (hn_tag[j+1]),
            .x2_o  (hn_x2[j+1]),
            .h_o   (hn_h[j+1])
        );
    end

    // Scale to the output format and divide by 46 with a reciprocal and one correction.
    always_comb
    begin
        c21     = NUM_W'({5'b0, hn_h[HORNER_STEPS]} * 36'd21);
        num     = hn_tag[HORNER_STEPS].flip ? ((NUM_W'(25) << 30) + c21)
                                            : ((NUM_W'(25) << 30) - c21);
        num_rnd = num + (NUM_W'(23) << SH);
        recip_prod = {BW'(0), b_reg} * {{(2*BW-MW){1'b0}}, M46[MW-1:0]};
        fin_rem = b2_reg - BW'(q0_reg * BW'(46));
        fin_q   = q0_reg + ((fin_rem >= BW'(46)) ? BW'(1) : BW'(0));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_tag_reg     <= '0;
            f2_tag_reg     <= '0;
            coef_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            f1_tag_reg     <= hn_tag[HORNER_STEPS];
            f2_tag_reg     <= f1_tag_reg;
            coef_valid_reg <= f2_tag_reg.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b_reg             <= num_rnd[NUM_W-1:SH];
            b2_reg            <= b_reg;
            q0_reg            <= recip_prod[2*BW-1:BW];
            status_reg        <= f2_tag_reg.status;
            coef_reg          <= (f2_tag_reg.status == ST_OK) ? fin_q[COEF_FRAC_BITS:0] : '0;
        end
    end

    assign coef_valid  = coef_valid_reg;
    assign coefficient = coef_reg;
    assign status      = status_reg;

endmodule

// ===== design/hwc_div_cell.sv =====
module hwc_div_cell (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   adv,
    input  hwc_pkg::hwc_tag_t      tag_i,
    input  logic [12:0]            den_i,
    input  logic [12:0]            rem_i,
    input  logic [31:0]            dq_i,
    output hwc_pkg::hwc_tag_t      tag_o,
    output logic [12:0]            den_o,
    output logic [12:0]            rem_o,
    output logic [31:0]            dq_o
);
    import hwc_pkg::*;

    logic              valid_reg;
    logic [1:0]        status_reg;
    logic [LEN_W-1:0]  den_reg;
    logic [LEN_W-1:0]  rem_reg;
    logic [TURN_W-1:0] dq_reg;
    logic [LEN_W:0]    trial;
    logic              ge;
    logic [LEN_W-1:0]  rem_next;
    logic [TURN_W-1:0] dq_next;

    // One restoring division step: bring down the next dividend bit, subtract if it fits.
    always_comb
    begin
        trial    = {rem_i, dq_i[TURN_W-1]};
        ge       = (trial >= {1'b0, den_i});
        rem_next = ge ? LEN_W'(trial - {1'b0, den_i}) : LEN_W'(trial);
        dq_next  = {dq_i[TURN_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= tag_i.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            status_reg <= tag_i.status;
            den_reg    <= den_i;
            rem_reg    <= rem_next;
            dq_reg     <= dq_next;
        end
    end

    assign tag_o = '{valid: valid_reg, status: status_reg, flip: 1'b0};
    assign den_o = den_reg;
    assign rem_o = rem_reg;
    assign dq_o  = dq_reg;

endmodule

// ===== design/hwc_horner_cell.sv =====
module hwc_horner_cell #(
    parameter int STEP = 0
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   adv,
    input  hwc_pkg::hwc_tag_t      tag_i,
    input  logic [31:0]            x2_i,
    input  logic [30:0]            h_i,
    output hwc_pkg::hwc_tag_t      tag_o,
    output logic [31:0]            x2_o,
    output logic [30:0]            h_o
);
    import hwc_pkg::*;

    localparam logic [7:0]  K = HORNER_K[STEP];
    localparam logic [31:0] M = HORNER_M[STEP];

    hwc_tag_t       tag1_reg;
    hwc_tag_t       tag2_reg;
    hwc_tag_t       tag3_reg;
    logic [SQ_W-1:0] x2a_reg;
    logic [SQ_W-1:0] x2b_reg;
    logic [SQ_W-1:0] x2c_reg;
    logic [31:0]     a1_reg;
    logic [31:0]     a2_reg;
    logic [31:0]     q0_reg;
    logic [ANG_W-1:0] h_reg;

    logic [62:0]     prod1;
    logic [63:0]     prod2;
    logic [31:0]     rem;
    logic [31:0]     q;
    logic [ANG_W-1:0] h_next;

    // The quotient estimate from the reciprocal is at most one short; the remainder fixes it.
    always_comb
    begin
        prod1  = {31'b0, x2_i} * {32'b0, h_i};
        prod2  = {32'b0, a1_reg} * {32'b0, M};
        rem    = a2_reg - 32'(q0_reg * {24'b0, K});
        q      = q0_reg + ((rem >= {24'b0, K}) ? 32'd1 : 32'd0);
        h_next = (q >= {1'b0, Q30_ONE}) ? '0 : ANG_W'({1'b0, Q30_ONE} - q);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag1_reg <= '0;
            tag2_reg <= '0;
            tag3_reg <= '0;
        end
        else if (adv)
        begin
            tag1_reg <= tag_i;
            tag2_reg <= tag1_reg;
            tag3_reg <= tag2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x2a_reg <= x2_i;
            x2b_reg <= x2a_reg;
            x2c_reg <= x2b_reg;
            a1_reg  <= prod1[61:30];
            a2_reg  <= a1_reg;
            q0_reg  <= prod2[63:32];
            h_reg   <= h_next;
        end
    end

    assign tag_o = tag3_reg;
    assign x2_o  = x2c_reg;
    assign h_o   = h_reg;

endmodule

// ===== design/hwc_checker.sv =====
module hwc_checker #(
    parameter int COEF_FRAC_BITS = 16
) (
    input logic                    clk,
    input logic                    rst_n,
    input logic                    sample_stall,
    input logic                    coef_valid,
    input logic                    coef_stall,
    input logic [COEF_FRAC_BITS:0] coefficient,
    input logic [1:0]              status
);
    import hwc_pkg::*;

    localparam logic [COEF_FRAC_BITS:0] ONE = {1'b1, {COEF_FRAC_BITS{1'b0}}};

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        coef_valid && coef_stall |=> coef_valid && $stable(coefficient) && $stable(status))
        else $error("stalled result changed");

    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        coef_valid && coef_stall |-> sample_stall)
        else $error("request taken while result is held");

    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        coef_valid |-> (status == ST_OK || status == ST_RANGE || status == ST_SHORT))
        else $error("status code out of range");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        coef_valid && status != ST_OK |-> coefficient == '0)
        else $error("coefficient not zero on error");

    a_bound: assert property (@(posedge clk) disable iff (!rst_n)
        coef_valid |-> coefficient <= ONE)
        else $error("coefficient above one");

endmodule

bind hamming_window_coefficient hwc_checker #(
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
) u_hwc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .sample_stall (sample_stall),
    .coef_valid   (coef_valid),
    .coef_stall   (coef_stall),
    .coefficient  (coefficient),
    .status       (status)
);
